// File: hw/rtl/wlfo_pkg.sv
// ============================================================================
// wlfo_pkg
// Shared types and constants for the wavetable LFO.
// ============================================================================
`default_nettype none
package wlfo_pkg;
    localparam int TableBits = 10;
    localparam int PhaseBits = TableBits + 16;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_PHASE = 2'd2,
        REQ_PEEK  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_INC    = 3'd1,
        REG_OFFSET = 3'd2,
        REG_SYM    = 3'd3,
        REG_DEPTH  = 3'd4,
        REG_AC     = 3'd5
    } t_reg;

    // Compute engine sequence states.
    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_WARP, S_RD, S_MUL, S_SUM, S_SCALE, S_SAT, S_OUT
    } t_eng_st;

    // One queued request between the front end and the compute engine.
    typedef struct packed {
        t_req                 req;
        logic [TableBits-1:0] index;
        logic [15:0]          value;
        logic [PhaseBits-1:0] phase;
    } t_cmd;

    typedef struct packed {
        logic                 enable;
        logic [PhaseBits-1:0] inc;
        logic [PhaseBits-1:0] offset;
        logic [15:0]          sym;
        logic [15:0]          depth;
        logic                 ac;
    } t_cfg;
endpackage
`default_nettype wire

// File: hw/rtl/wlfo_front.sv
// ============================================================================
// wlfo_front
// Accepts requests and holds them in a two-entry queue for the engine.
// ============================================================================
`default_nettype none
module wlfo_front import wlfo_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_take
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// File: hw/rtl/wlfo_div.sv
// ============================================================================
// wlfo_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none
module wlfo_div import wlfo_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [40:0] i_num,
    input  wire logic [16:0] i_den,
    output logic             o_done,
    output logic [40:0]      o_quo
);
    logic [40:0] r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    logic [18:0] w_diff;

    assign w_sh   = {r_rem[16:0], r_quo[40]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};
    assign o_quo  = r_quo;

    // Shift-subtract iteration over the 41 numerator bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd41;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[18]) begin
                r_rem <= w_diff[17:0];
                r_quo <= {r_quo[39:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[39:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/wlfo_engine.sv
// ============================================================================
// wlfo_engine
// Back end: phase state, wave table, warp, interpolation and scaling.
// ============================================================================
`default_nettype none
module wlfo_engine import wlfo_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cfg         i_cfg,
    input  wire logic         i_valid,
    input  wire t_cmd         i_cmd,
    output logic              o_take,
    output logic              o_res_valid,
    output logic signed [16:0] o_res,
    input  wire logic         i_res_free
);
    localparam logic [PhaseBits:0] Period = {1'b1, {PhaseBits{1'b0}}};
    localparam logic [PhaseBits-1:0] Half = {1'b1, {(PhaseBits-1){1'b0}}};

    t_eng_st r_st, n_st;
    logic [15:0] r_mem [1 << TableBits];
    logic [PhaseBits-1:0] r_acc, r_p, r_r;
    logic        r_lo;
    t_req        r_req;
    logic [15:0] r_s1, r_s2;
    logic [32:0] r_m1, r_m2;
    logic signed [17:0] r_x;
    logic signed [35:0] r_y;
    logic signed [16:0] r_out;
    logic signed [16:0] r_res;
    logic        r_full;

    logic [PhaseBits:0]   w_sum, w_nxt;
    logic [PhaseBits-1:0] w_p, w_inc;
    logic [PhaseBits-1:0] w_c;
    logic        w_lo, w_start, w_done;
    logic [40:0] w_num, w_quo;
    logic [16:0] w_den;
    logic [41:0] w_r;
    logic [TableBits-1:0] w_i1, w_i2;
    logic [16:0] w_f;
    logic [33:0] w_v;
    logic signed [17:0] w_x;
    logic signed [35:0] w_q;

    // Offset phase and warp region.
    assign w_sum = {1'b0, r_acc} + {1'b0, i_cfg.offset};
    assign w_p   = w_sum[PhaseBits-1:0];
    assign w_c   = {i_cfg.sym, {TableBits{1'b0}}};
    assign w_lo  = (w_p < w_c);
    assign w_num = r_lo ? {r_p, 15'b0} : {r_p - w_c, 15'b0};
    assign w_den = r_lo ? {1'b0, i_cfg.sym} : 17'h10000 - {1'b0, i_cfg.sym};
    assign w_start = (r_st == S_DIV);

    wlfo_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quo(w_quo)
    );

    assign w_r = r_lo ? {1'b0, w_quo} : {1'b0, w_quo} + {16'b0, Half};
    assign w_i1 = r_r[PhaseBits-1:16];
    assign w_i2 = w_i1 + 1'b1;
    assign w_f  = {1'b0, r_r[15:0]};
    assign w_v  = {1'b0, r_m1} + {1'b0, r_m2} + 34'd32768;
    // The interpolated value never exceeds 16 bits, so the shifted copy stays positive.
    assign w_x  = i_cfg.ac ? $signed({w_v[32:16], 1'b0}) - 18'sd32768
                           : $signed({1'b0, w_v[32:16]});
    assign w_q  = r_y >>> 15;

    assign w_inc = (i_cfg.inc > Half) ? Half : i_cfg.inc;
    assign w_nxt = {1'b0, r_acc} + {1'b0, w_inc};

    assign o_take      = (r_st == S_IDLE) && i_valid;
    assign o_res_valid = r_full;
    assign o_res       = r_res;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_valid) begin
                if (i_cmd.req == REQ_TICK || i_cmd.req == REQ_PEEK)
                    n_st = i_cfg.enable ? S_DIV : S_OUT;
            end
            S_DIV:   n_st = S_WARP;
            S_WARP:  if (w_done) n_st = S_RD;
            S_RD:    n_st = S_MUL;
            S_MUL:   n_st = S_SUM;
            S_SUM:   n_st = S_SCALE;
            S_SCALE: n_st = S_SAT;
            S_SAT:   n_st = S_OUT;
            S_OUT:   if (!r_full) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_acc  <= '0;
            r_full <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_res_free) r_full <= 1'b0;
            if (o_take && i_cmd.req == REQ_PHASE) r_acc <= i_cmd.phase;
            if (r_st == S_OUT && !r_full) begin
                r_full <= 1'b1;
                if (r_req == REQ_TICK && i_cfg.enable)
                    r_acc <= (w_nxt >= Period) ? w_nxt[PhaseBits-1:0] - Period[PhaseBits-1:0]
                                               : w_nxt[PhaseBits-1:0];
            end
        end
    end

    // Datapath registers and table memory.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_req <= i_cmd.req;
            r_p   <= w_p;
            r_lo  <= w_lo;
            r_out <= 17'sd32768;
            if (i_cmd.req == REQ_WRITE) r_mem[i_cmd.index] <= i_cmd.value;
        end
        if (r_st == S_WARP && w_done)
            r_r <= (w_r >= {15'b0, Period}) ? {{TableBits{1'b1}}, 16'b0}
                                            : w_r[PhaseBits-1:0];
        if (r_st == S_RD) begin
            r_s1 <= r_mem[w_i1];
            r_s2 <= r_mem[w_i2];
        end
        if (r_st == S_MUL) begin
            r_m1 <= {1'b0, r_s1} * (17'h10000 - w_f);
            r_m2 <= {1'b0, r_s2} * w_f;
        end
        if (r_st == S_SUM)   r_x <= w_x;
        if (r_st == S_SCALE) r_y <= r_x * $signed({2'b0, i_cfg.depth}) + 36'sd16384;
        if (r_st == S_SAT)
            r_out <= (w_q > 36'sd32768) ? 17'sd32768 :
                     (w_q < -36'sd32768) ? -17'sd32768 : w_q[16:0];
        // The result register holds the sample until it is popped.
        if (r_st == S_OUT && !r_full) r_res <= r_out;
    end
endmodule
`default_nettype wire

// File: hw/rtl/wavetable_lfo_symmetry_interp.sv
// ============================================================================
// wavetable_lfo_symmetry_interp
// Wavetable LFO with symmetry warp, linear interpolation and depth.
// ============================================================================
// Channel   Handshake        Payload
// input     i_push / o_full  i_req_type, i_table_index, i_table_value, i_new_phase
// result    o_empty / i_pop  o_lfo_sample
// config    APB write/read   six registers at 4*i
//
// A tick or peek runs the serial warp divider, then the read, multiply, sum, scale
// and saturate steps; table writes and set phase complete in the engine without leaving idle.
// A disabled tick skips the divider and those steps. Reset is synchronous; the table
// holds no reset value. A two-entry request queue and a separate result
// register let input continue while a result waits for a pop.
`default_nettype none
module wavetable_lfo_symmetry_interp import wlfo_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [9:0]  i_table_index,
    input  wire logic [15:0] i_table_value,
    input  wire logic [25:0] i_new_phase,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic signed [16:0] o_lfo_sample,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_cfg r_cfg;
    t_cmd w_cmd, w_qcmd;
    logic w_qv, w_take, w_rv;

    assign pready = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{enable: 1'b1, inc: '0, offset: '0, sym: 16'd32768,
                       depth: 16'd32768, ac: 1'b0};
        end else if (psel && penable && pwrite) begin
            case (t_reg'(paddr[4:2]))
                REG_ENABLE: r_cfg.enable <= pwdata[0];
                REG_INC:    r_cfg.inc    <= pwdata[25:0];
                REG_OFFSET: r_cfg.offset <= pwdata[25:0];
                REG_SYM:    r_cfg.sym    <= pwdata[15:0];
                REG_DEPTH:  r_cfg.depth  <= pwdata[15:0];
                REG_AC:     r_cfg.ac     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (t_reg'(paddr[4:2]))
            REG_ENABLE: prdata = {31'b0, r_cfg.enable};
            REG_INC:    prdata = {6'b0, r_cfg.inc};
            REG_OFFSET: prdata = {6'b0, r_cfg.offset};
            REG_SYM:    prdata = {16'b0, r_cfg.sym};
            REG_DEPTH:  prdata = {16'b0, r_cfg.depth};
            REG_AC:     prdata = {31'b0, r_cfg.ac};
            default:    prdata = '0;
        endcase
    end

    assign w_cmd = '{req: t_req'(i_req_type), index: i_table_index,
                     value: i_table_value, phase: i_new_phase};

    wlfo_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_cmd(w_cmd),
        .o_full(o_full), .o_valid(w_qv), .o_cmd(w_qcmd), .i_take(w_take)
    );

    wlfo_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(w_qv),
        .i_cmd(w_qcmd), .o_take(w_take), .o_res_valid(w_rv),
        .o_res(o_lfo_sample), .i_res_free(i_pop && w_rv)
    );

    assign o_empty = !w_rv;
endmodule
`default_nettype wire

// File: dv/testbench.sv
// ============================================================================
// Wavetable LFO testbench
// Fills the waveform table, then drives directed and random requests while
// an in-bench oscillator model predicts every sample; each popped sample is
// compared against the oldest prediction.
// ============================================================================
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wlfo_pkg::*;

    localparam longint Period = 64'd1024 << 16;
    localparam int CycleLimit = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [1:0]  i_req_type;
    logic [9:0]  i_table_index;
    logic [15:0] i_table_value;
    logic [25:0] i_new_phase;
    logic        o_empty;
    logic        i_pop;
    logic signed [16:0] o_lfo_sample;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wavetable_lfo_symmetry_interp dut (.*);

    // Oscillator model state and register copies.
    longint osc_enable, osc_inc, osc_offset, osc_sym, osc_depth, osc_ac;
    longint osc_phase;
    longint wave_mem [1024];

    logic [16:0] sample_q [$];
    int          mismatches;
    int          samples_seen;
    int          requests_sent;
    int          cycles;
    bit          quiet;
    int          pop_hold;

    // Clock and cycle watchdog.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout with %0d samples outstanding", $realtime, sample_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample value the oscillator produces from the current state.
    function automatic logic [16:0] lfo_value();
        longint p, c, r, i1, i2, f, v, x, y;
        if (osc_enable == 0) return 17'h08000;
        p = (osc_phase + osc_offset) % Period;
        c = osc_sym * 1024;
        if (p < c) r = (p * 32768) / osc_sym;
        else r = Period / 2 + ((p - c) * 32768) / (65536 - osc_sym);
        if (r >= Period) r = 64'd1023 << 16;
        i1 = (r >> 16) % 1024;
        i2 = (i1 + 1) % 1024;
        f = r & 64'hFFFF;
        v = (wave_mem[i1] * (65536 - f) + wave_mem[i2] * f + 32768) >> 16;
        x = osc_ac != 0 ? 2 * v - 32768 : v;
        // Floor division by 32768 after the half offset rounds halves upward.
        y = (x * osc_depth + 16384) >>> 15;
        if (y > 32768) y = 32768;
        if (y < -32768) y = -32768;
        return y[16:0];
    endfunction

    // Apply one accepted request to the model.
    function automatic void osc_apply(t_req kind, logic [9:0] idx, logic [15:0] val,
                                      logic [25:0] ph);
        longint step;
        case (kind)
            REQ_WRITE: wave_mem[idx] = val;
            REQ_PHASE: osc_phase = ph % Period;
            default: begin
                sample_q.push_back(lfo_value());
                if (kind == REQ_TICK && osc_enable != 0) begin
                    step = osc_inc > Period / 2 ? Period / 2 : osc_inc;
                    osc_phase = osc_phase + step;
                    if (osc_phase >= Period) osc_phase = osc_phase - Period;
                end
            end
        endcase
    endfunction

    // Result side: random pop stalls and the sample check.
    initial begin
        i_pop = 1'b0;
        pop_hold = 0;
        forever begin
            @(posedge i_clk);
            if (pop_hold > 0 && !quiet) begin
                i_pop <= 1'b0;
                pop_hold = pop_hold - 1;
            end else begin
                i_pop <= 1'b1;
                case ($urandom_range(0, 99)) inside
                    [0:9]:   pop_hold = $urandom_range(1, 4);
                    [10:11]: pop_hold = $urandom_range(20, 120);
                    default: pop_hold = 0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            samples_seen <= samples_seen + 1;
            if (sample_q.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %0d",
                         $realtime, o_lfo_sample);
                mismatches <= mismatches + 1;
            end else begin
                if (o_lfo_sample !== sample_q[0]) begin
                    $display("%0t: lfo_sample mismatch, expected %0d, actual %0d",
                             $realtime, $signed(sample_q[0]), o_lfo_sample);
                    mismatches <= mismatches + 1;
                end
                void'(sample_q.pop_front());
            end
        end
    end

    // Send one request, with a random gap unless running back to back.
    task automatic send_req(t_req kind, logic [9:0] idx, logic [15:0] val, logic [25:0] ph);
        int gap;
        gap = 0;
        if (!quiet) begin
            case ($urandom_range(0, 99)) inside
                [0:14]:  gap = $urandom_range(1, 3);
                [15:17]: gap = $urandom_range(20, 80);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_req_type <= kind;
        i_table_index <= idx;
        i_table_value <= val;
        i_new_phase <= ph;
        do @(posedge i_clk); while (o_full);
        osc_apply(kind, idx, val, ph);
        requests_sent++;
    endtask

    // Wait for every sample, then let trailing writes finish in the engine.
    task automatic settle();
        i_push <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg rsel, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {rsel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (rsel)
            REG_ENABLE: osc_enable = data & 1;
            REG_INC:    osc_inc = data & 32'h3FF_FFFF;
            REG_OFFSET: osc_offset = data & 32'h3FF_FFFF;
            REG_SYM:    osc_sym = data & 32'hFFFF;
            REG_DEPTH:  osc_depth = data & 32'hFFFF;
            default:    osc_ac = data & 1;
        endcase
    endtask

    task automatic set_all(logic en, logic [25:0] inc, logic [25:0] offs, logic [15:0] sym,
                           logic [15:0] dep, logic ac);
        settle();
        reg_write(REG_ENABLE, 32'(en));
        reg_write(REG_INC, 32'(inc));
        reg_write(REG_OFFSET, 32'(offs));
        reg_write(REG_SYM, 32'(sym));
        reg_write(REG_DEPTH, 32'(dep));
        reg_write(REG_AC, 32'(ac));
    endtask

    // Every entry must be written before any tick can read it.
    task automatic test_fill_table();
        quiet = 1'b1;
        for (int i = 0; i < 1024; i++)
            send_req(REQ_WRITE, i[9:0], 16'($urandom_range(0, 32768)), '0);
        quiet = 1'b0;
    endtask

    // Directed corners: operations, wrap, disable, saturation, extreme settings.
    task automatic test_directed();
        send_req(REQ_PEEK, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_WRITE, 10'd1023, 16'd32768, '0);
        send_req(REQ_WRITE, 10'd0, 16'd0, '0);
        send_req(REQ_PHASE, '0, '0, 26'h3FF_FFFF);
        send_req(REQ_PEEK, '0, '0, '0);
        send_req(REQ_PHASE, '0, '0, 26'h3FF_0000);
        send_req(REQ_TICK, '0, '0, '0);
        // Oversized table values saturate the result.
        send_req(REQ_WRITE, 10'd512, 16'hFFFF, '0);
        send_req(REQ_WRITE, 10'd513, 16'hFFFF, '0);
        send_req(REQ_PHASE, '0, '0, 26'd512 << 16);
        set_all(1'b1, 26'h3FF_FFFF, 26'h3FF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_PEEK, '0, '0, '0);
        // Zero symmetry sends every phase to the second half.
        set_all(1'b1, 26'd33554432, 26'd0, 16'd0, 16'd0, 1'b0);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_PEEK, '0, '0, '0);
        // Disabled: constant full scale and no advance.
        set_all(1'b0, 26'd70000, 26'd12345, 16'd6554, 16'd32768, 1'b1);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, '0);
        set_all(1'b1, 26'd70000, 26'd12345, 16'd58982, 16'd32768, 1'b1);
        send_req(REQ_PEEK, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, '0);
        send_req(REQ_PHASE, '0, '0, '0);
        send_req(REQ_TICK, '0, '0, '0);
    endtask

    task automatic random_config();
        logic [25:0] inc, offs;
        logic [15:0] sym, dep;
        inc = $urandom_range(0, 3) == 0 ? 26'($urandom()) : 26'($urandom_range(0, 4_000_000));
        offs = 26'($urandom());
        case ($urandom_range(0, 5))
            0: sym = 16'd6554;
            1: sym = 16'd58982;
            2: sym = 16'($urandom());
            default: sym = 16'($urandom_range(6554, 58982));
        endcase
        dep = $urandom_range(0, 5) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768));
        set_all($urandom_range(0, 7) != 0, inc, offs, sym, dep, 1'($urandom()));
    endtask

    // Random traffic in phases, each under a fresh setting.
    task automatic test_random();
        logic [15:0] val;
        for (int ph = 0; ph < 5; ph++) begin
            random_config();
            quiet = (ph == 1);
            for (int n = 0; n < 120; n++) begin
                case ($urandom_range(0, 99)) inside
                    [0:44]: send_req(REQ_TICK, '0, '0, '0);
                    [45:64]: send_req(REQ_PEEK, '0, '0, '0);
                    [65:89]: begin
                        val = $urandom_range(0, 9) == 0 ? 16'($urandom())
                                                         : 16'($urandom_range(0, 32768));
                        send_req(REQ_WRITE, 10'($urandom()), val, '0);
                    end
                    default: send_req(REQ_PHASE, '0, '0, 26'($urandom()));
                endcase
            end
            quiet = 1'b0;
        end
    endtask

    // Sender holds off until the pipeline has fully drained, then resumes.
    task automatic test_drain_pause();
        for (int n = 0; n < 10; n++) send_req(REQ_TICK, '0, '0, '0);
        i_push <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 10; n++) send_req(REQ_TICK, '0, '0, '0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_req_type = REQ_TICK;
        i_table_index = '0;
        i_table_value = '0;
        i_new_phase = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        samples_seen = 0;
        requests_sent = 0;
        cycles = 0;
        quiet = 1'b0;
        osc_enable = 1;
        osc_inc = 0;
        osc_offset = 0;
        osc_sym = 32768;
        osc_depth = 32768;
        osc_ac = 0;
        osc_phase = 0;
        foreach (wave_mem[i]) wave_mem[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_table();
        test_directed();
        test_drain_pause();
        test_random();

        settle();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d requests and %0d samples over table fill, corners,",
                 requests_sent, samples_seen);
        $display("disable, saturation and random settings with handshake stalls.");
        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
